/* rtl/core/tccp_pkg.sv */
package tccp_pkg;

  localparam int CODE_W = 16;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int CCNT_W = 8;
  localparam int RCNT_W = 7;
  localparam int CFG_IDX_W = 1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b1;

  localparam logic [CCNT_W-1:0] COLUMN_COUNT_RST = 8'd96;
  localparam logic [RCNT_W-1:0] ROW_COUNT_RST    = 7'd31;
  localparam logic [CCNT_W-1:0] COLUMN_MIN = 8'd2;
  localparam logic [CCNT_W-1:0] COLUMN_MAX = 8'd128;
  localparam logic [RCNT_W-1:0] ROW_MIN    = 7'd2;
  localparam logic [RCNT_W-1:0] ROW_MAX    = 7'd64;

  // character codes
  localparam logic [CODE_W-1:0] CHR_CTRL_LAST = 16'h001f;
  localparam logic [CODE_W-1:0] CHR_DEL       = 16'h007f;
  localparam logic [CODE_W-1:0] CHR_TAB       = 16'h0009;
  localparam logic [CODE_W-1:0] CHR_LF        = 16'h000a;
  localparam logic [CODE_W-1:0] CHR_CR        = 16'h000d;
  localparam logic [CODE_W-1:0] CHR_WIDE_MIN  = 16'h0100;
  localparam logic [CODE_W-1:0] LEAD_A_LO     = 16'h0080;
  localparam logic [CODE_W-1:0] LEAD_A_HI     = 16'h009f;
  localparam logic [CODE_W-1:0] LEAD_B_LO     = 16'h00e0;
  localparam logic [CODE_W-1:0] LEAD_B_HI     = 16'h00ff;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] char_code;
  } tccp_item_t;

  function automatic logic is_lead_code(input logic [CODE_W-1:0] c);
    is_lead_code = ((c >= LEAD_A_LO) && (c <= LEAD_A_HI)) ||
                   ((c >= LEAD_B_LO) && (c <= LEAD_B_HI));
  endfunction

endpackage

/* rtl/core/tccp_in_if.sv */
interface tccp_in_if;
  logic                         valid;
  logic                         ready;
  logic [tccp_pkg::CODE_W-1:0]  char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

/* rtl/core/tccp_out_if.sv */
interface tccp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         scroll_up;
  logic                         draw_valid;
  logic [tccp_pkg::COL_W-1:0]   draw_column;
  logic [tccp_pkg::ROW_W-1:0]   draw_row;
  logic [tccp_pkg::CODE_W-1:0]  draw_code;

  modport source (output valid, output scroll_up, output draw_valid, output draw_column,
                  output draw_row, output draw_code, input ready);
  modport sink (input valid, input scroll_up, input draw_valid, input draw_column,
                input draw_row, input draw_code, output ready);
endinterface

/* rtl/core/tccp_in_reg.sv */
module tccp_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  tccp_in_if.sink              in_ch,
  input  logic                 take,
  output tccp_pkg::tccp_item_t item
);
  import tccp_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [CODE_W-1:0] code_r;

  assign in_ch.ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.ready) begin
      valid_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      code_r <= in_ch.char_code;
    end
  end

  assign item.valid     = valid_r;
  assign item.char_code = code_r;
endmodule

/* rtl/core/tccp_core.sv */
module tccp_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tccp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tccp_pkg::CCNT_W-1:0]       cfg_wdata,
  input  tccp_pkg::tccp_item_t              item,
  output logic                              take,
  tccp_out_if.source                        out_ch
);
  import tccp_pkg::*;

  logic [CCNT_W-1:0] column_count_r;
  logic [RCNT_W-1:0] row_count_r;
  logic [CCNT_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [7:0]        lead_r, lead_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              scroll_r, scroll_nxt;
  logic              draw_r, draw_nxt;
  logic [COL_W-1:0]  dcol_r, dcol_nxt;
  logic [ROW_W-1:0]  drow_r, drow_nxt;
  logic [CODE_W-1:0] dcode_r, dcode_nxt;

  logic [CCNT_W-1:0] cols;
  logic [RCNT_W-1:0] rows;
  logic [CODE_W-1:0] code;
  logic              is_ctrl;
  logic [CODE_W-1:0] eff_code;
  logic              wide;
  logic [CCNT_W:0]   tab_col;
  logic              md_scroll;
  logic [ROW_W-1:0]  md_row;
  logic [CCNT_W-1:0] col_a;

  assign take = item.valid && (!out_valid_r || out_ch.ready);

  // saturate the configured counts to their usable ranges
  always_comb begin
    cols = column_count_r;
    if (column_count_r < COLUMN_MIN) cols = COLUMN_MIN;
    if (column_count_r > COLUMN_MAX) cols = COLUMN_MAX;
    rows = row_count_r;
    if (row_count_r < ROW_MIN) rows = ROW_MIN;
    if (row_count_r > ROW_MAX) rows = ROW_MAX;
  end

  assign code    = item.char_code;
  assign is_ctrl = (code <= CHR_CTRL_LAST) || (code == CHR_DEL);
  assign eff_code = ((lead_r != 8'd0) && (code <= LEAD_B_HI)) ?
                    {lead_r, code[7:0]} : code;
  assign wide    = eff_code >= CHR_WIDE_MIN;

  assign tab_col = ({1'b0, col_r} + 9'd8) & ~9'd7;

  // one row down; a row past the bottom lands on the last row
  assign md_scroll = ({1'b0, row_r} + 7'd1) >= rows;
  assign md_row    = md_scroll ? ROW_W'(rows - 7'd1) : row_r + 6'd1;

  // wide character that would straddle the edge wraps early
  assign col_a = (wide && (({1'b0, col_r} + 9'd1) >= {1'b0, cols})) ? cols : col_r;

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    lead_nxt   = 8'd0;
    scroll_nxt = 1'b0;
    draw_nxt   = 1'b0;
    dcol_nxt   = '0;
    drow_nxt   = '0;
    dcode_nxt  = '0;
    if (is_ctrl) begin
      priority if (code == CHR_TAB) begin
        col_nxt = (tab_col > {1'b0, cols}) ? cols : tab_col[CCNT_W-1:0];
      end else if (code == CHR_LF) begin
        scroll_nxt = md_scroll;
        row_nxt    = md_row;
      end else if (code == CHR_CR) begin
        col_nxt = '0;
      end else begin
        col_nxt = col_r;
      end
    end else begin
      col_nxt = col_a;
      if (col_a >= cols) begin
        col_nxt    = '0;
        scroll_nxt = md_scroll;
        row_nxt    = md_row;
      end
      if (is_lead_code(eff_code)) begin
        lead_nxt = eff_code[7:0];
      end else begin
        draw_nxt  = 1'b1;
        dcol_nxt  = col_nxt[COL_W-1:0];
        drow_nxt  = row_nxt;
        dcode_nxt = eff_code;
        col_nxt   = col_nxt + (wide ? 8'd2 : 8'd1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (take) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= COLUMN_COUNT_RST;
      row_count_r    <= ROW_COUNT_RST;
      col_r          <= '0;
      row_r          <= '0;
      lead_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLUMN_COUNT: column_count_r <= cfg_wdata;
          CFG_ROW_COUNT:    row_count_r    <= cfg_wdata[RCNT_W-1:0];
          default:          column_count_r <= column_count_r;
        endcase
      end
      if (take) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        lead_r <= lead_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      scroll_r <= scroll_nxt;
      draw_r   <= draw_nxt;
      dcol_r   <= dcol_nxt;
      drow_r   <= drow_nxt;
      dcode_r  <= dcode_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.scroll_up   = scroll_r;
  assign out_ch.draw_valid  = draw_r;
  assign out_ch.draw_column = dcol_r;
  assign out_ch.draw_row    = drow_r;
  assign out_ch.draw_code   = dcode_r;
endmodule

/* rtl/core/text_console_cursor_placer.sv */
// path: input register (tccp_in_reg), then the result register (tccp_core)
// throughput: one item per cycle if out_ch is ready; cursor state updates in the
//   same cycle the result register loads, so one register stage sets the rate
// reset: synchronous active-low rst_n clears cursor, lead byte and valids and
//   loads column_count = 96, row_count = 31
module text_console_cursor_placer (
  input  logic                           clk,
  input  logic                           rst_n,
  tccp_in_if.sink                        in_ch,
  tccp_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [tccp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tccp_pkg::CCNT_W-1:0]    cfg_wdata
);
  import tccp_pkg::*;

  tccp_item_t item;
  logic       take;

  tccp_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .item  (item)
  );

  tccp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .take      (take),
    .out_ch    (out_ch)
  );
endmodule

/* rtl/core/tccp_checker.sv */
module tccp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          scroll_up,
  input logic                          draw_valid,
  input logic [tccp_pkg::COL_W-1:0]    draw_column,
  input logic [tccp_pkg::ROW_W-1:0]    draw_row,
  input logic [tccp_pkg::CODE_W-1:0]   draw_code
);
  import tccp_pkg::*;

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an item that draws nothing carries zero position and code
  a_no_draw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !draw_valid |-> draw_column == '0 && draw_row == '0 && draw_code == '0)
    else $error("non-draw item with nonzero fields");

  // control codes and held lead bytes are never drawn
  a_draw_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && draw_valid |-> draw_code > CHR_CTRL_LAST && draw_code != CHR_DEL &&
      !is_lead_code(draw_code))
    else $error("control or lead code drawn");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(scroll_up) && $stable(draw_valid) &&
      $stable(draw_column) && $stable(draw_row) && $stable(draw_code))
    else $error("stalled result changed");
endmodule

bind text_console_cursor_placer tccp_checker u_tccp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .scroll_up   (out_ch.scroll_up),
  .draw_valid  (out_ch.draw_valid),
  .draw_column (out_ch.draw_column),
  .draw_row    (out_ch.draw_row),
  .draw_code   (out_ch.draw_code)
);

/* test/text_console_cursor_placer_tb.sv */
`timescale 1ns / 100ps

module text_console_cursor_placer_tb;
  import tccp_pkg::*;

  typedef struct packed {
    logic              scroll_up;
    logic              draw_valid;
    logic [COL_W-1:0]  draw_column;
    logic [ROW_W-1:0]  draw_row;
    logic [CODE_W-1:0] draw_code;
  } placement_t;

  // one directed row: a character item, or a register write with the value in code[7:0]
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CODE_W-1:0]    code;
    logic                 known;
    placement_t           want;
  } dir_row_t;

  localparam placement_t NO_DRAW = '0;

  localparam dir_row_t DIR_TAB [0:26] = '{
    '{1'b0, '0, 16'h0041, 1'b1, '{1'b0, 1'b1, 7'd0, 6'd0, 16'h0041}},
    '{1'b0, '0, CHR_TAB, 1'b1, NO_DRAW},
    '{1'b0, '0, CHR_CR, 1'b1, NO_DRAW},
    '{1'b0, '0, CHR_LF, 1'b1, NO_DRAW},
    '{1'b0, '0, LEAD_A_LO, 1'b1, NO_DRAW},
    '{1'b0, '0, 16'h0041, 1'b1, '{1'b0, 1'b1, 7'd0, 6'd1, 16'h8041}},
    '{1'b0, '0, LEAD_B_LO, 1'b1, NO_DRAW},
    '{1'b0, '0, CHR_CR, 1'b1, NO_DRAW},
    '{1'b0, '0, 16'h0042, 1'b0, NO_DRAW},
    '{1'b0, '0, LEAD_A_HI, 1'b1, NO_DRAW},
    '{1'b0, '0, 16'h1234, 1'b0, NO_DRAW},
    '{1'b0, '0, CHR_DEL, 1'b1, NO_DRAW},
    '{1'b0, '0, 16'hffff, 1'b0, NO_DRAW},
    '{1'b0, '0, LEAD_B_HI, 1'b1, NO_DRAW},
    '{1'b0, '0, LEAD_B_HI, 1'b0, NO_DRAW},
    '{1'b0, '0, 16'h0000, 1'b1, NO_DRAW},
    '{1'b0, '0, 16'h00a0, 1'b0, NO_DRAW},
    '{1'b0, '0, 16'h007e, 1'b0, NO_DRAW},
    '{1'b0, '0, 16'h0020, 1'b0, NO_DRAW},
    // shrink the screen under the cursor
    '{1'b1, CFG_COLUMN_COUNT, 16'h0002, 1'b0, NO_DRAW},
    '{1'b1, CFG_ROW_COUNT, 16'h0002, 1'b0, NO_DRAW},
    '{1'b0, '0, 16'h0041, 1'b0, NO_DRAW},
    '{1'b0, '0, 16'h3031, 1'b0, NO_DRAW},
    '{1'b0, '0, CHR_TAB, 1'b0, NO_DRAW},
    '{1'b0, '0, LEAD_A_LO, 1'b0, NO_DRAW},
    '{1'b0, '0, 16'h0041, 1'b0, NO_DRAW},
    '{1'b0, '0, CHR_LF, 1'b0, NO_DRAW}
  };

  localparam logic [7:0] PHASE_COLS [0:8] = '{8'd128, 8'd0, 8'd255, 8'd40, 8'd1, 8'd129,
                                              8'd0, 8'd96, 8'd0};
  localparam logic [7:0] PHASE_ROWS [0:8] = '{8'd64, 8'd0, 8'd255, 8'd10, 8'd1, 8'd65,
                                              8'd0, 8'd31, 8'd0};
  localparam int PHASE_ITEMS = 170;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CCNT_W-1:0]    cfg_wdata;

  tccp_in_if  in_ch ();
  tccp_out_if out_ch ();

  text_console_cursor_placer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // cursor model
  logic [CCNT_W-1:0] col_count_reg;
  logic [RCNT_W-1:0] row_count_reg;
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [CODE_W-1:0] held_lead;

  placement_t  placement_q [$];
  int          mismatch_count;
  int          items_sent;
  int unsigned tx_mode;
  int unsigned rx_mode;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_wait(input int unsigned mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 15);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 0;
    endcase
  endfunction

  // cursor moves down one row, sticking on the last row and scrolling there
  function automatic logic row_down(input int unsigned rows);
    if (cur_row + 1 >= rows) begin
      cur_row = rows - 1;
      return 1'b1;
    end
    cur_row = cur_row + 1;
    return 1'b0;
  endfunction

  function automatic placement_t place_char(input logic [CODE_W-1:0] code_in);
    int unsigned       cols;
    int unsigned       rows;
    int unsigned       nxt;
    logic [CODE_W-1:0] code;
    placement_t        r;
    cols = 32'(col_count_reg);
    if (cols < 32'(COLUMN_MIN)) cols = 32'(COLUMN_MIN);
    if (cols > 32'(COLUMN_MAX)) cols = 32'(COLUMN_MAX);
    rows = 32'(row_count_reg);
    if (rows < 32'(ROW_MIN)) rows = 32'(ROW_MIN);
    if (rows > 32'(ROW_MAX)) rows = 32'(ROW_MAX);
    r = '0;
    code = code_in;
    if (code <= CHR_CTRL_LAST || code == CHR_DEL) begin
      held_lead = '0;
      if (code == CHR_TAB) begin
        nxt = (cur_col + 8) & ~32'd7;
        if (nxt > cols) nxt = cols;
        cur_col = nxt;
      end else if (code == CHR_LF) begin
        r.scroll_up = row_down(rows);
      end else if (code == CHR_CR) begin
        cur_col = 0;
      end
    end else begin
      if (held_lead != '0) begin
        if (code < CHR_WIDE_MIN) code = {held_lead[7:0], code[7:0]};
        held_lead = '0;
      end
      // a wide character never straddles the right edge
      if (code >= CHR_WIDE_MIN && cur_col + 1 >= cols) cur_col = cols;
      if (cur_col >= cols) begin
        cur_col = 0;
        r.scroll_up = row_down(rows);
      end
      if ((code >= LEAD_A_LO && code <= LEAD_A_HI) ||
          (code >= LEAD_B_LO && code <= LEAD_B_HI)) begin
        held_lead = code;
      end else begin
        r.draw_valid  = 1'b1;
        r.draw_column = cur_col[COL_W-1:0];
        r.draw_row    = cur_row[ROW_W-1:0];
        r.draw_code   = code;
        cur_col = cur_col + ((code >= CHR_WIDE_MIN) ? 2 : 1);
      end
    end
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return CHR_LF;
    if (r < 16) return CHR_CR;
    if (r < 24) return CHR_TAB;
    if (r < 28) return ($urandom_range(0, 4) == 0) ? CHR_DEL
                                                   : CODE_W'($urandom_range(0, CHR_CTRL_LAST));
    if (r < 60) return CODE_W'($urandom_range(16'h0020, 16'h007e));
    if (r < 66) return CODE_W'($urandom_range(16'h00a0, 16'h00df));
    // lone lead byte, the next pick decides what it joins with
    if (r < 72) return ($urandom_range(0, 1) != 0) ? CODE_W'($urandom_range(LEAD_A_LO, LEAD_A_HI))
                                                   : CODE_W'($urandom_range(LEAD_B_LO, LEAD_B_HI));
    if (r < 88) return CODE_W'($urandom_range(CHR_WIDE_MIN, 16'hffff));
    return CODE_W'($urandom_range(0, 16'hffff));
  endfunction

  task automatic send_char(input logic [CODE_W-1:0] code, input logic known,
                           input placement_t want);
    int unsigned gap;
    placement_t  p;
    gap = pick_wait(tx_mode);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= code;
    do @(posedge clk); while (!in_ch.ready);
    p = place_char(code);
    placement_q.push_back(known ? want : p);
    items_sent++;
    if (items_sent % 40 == 0) tx_mode = $urandom_range(0, 2);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CCNT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COLUMN_COUNT) col_count_reg = val;
    else row_count_reg = val[RCNT_W-1:0];
  endtask

  // result side back-pressure
  initial begin
    int unsigned stall;
    int          taken;
    taken = 0;
    out_ch.ready = 1'b0;
    rx_mode = 2;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = pick_wait(rx_mode);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      if (taken % 40 == 0) rx_mode = $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    placement_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (placement_q.size() == 0) begin
        $error("result with no item outstanding");
        mismatch_count++;
      end else begin
        want = placement_q.pop_front();
        if (out_ch.scroll_up !== want.scroll_up) begin
          $error("scroll_up: expected %0d, got %0d", want.scroll_up, out_ch.scroll_up);
          mismatch_count++;
        end
        if (out_ch.draw_valid !== want.draw_valid) begin
          $error("draw_valid: expected %0d, got %0d", want.draw_valid, out_ch.draw_valid);
          mismatch_count++;
        end
        if (out_ch.draw_column !== want.draw_column) begin
          $error("draw_column: expected %0d, got %0d", want.draw_column, out_ch.draw_column);
          mismatch_count++;
        end
        if (out_ch.draw_row !== want.draw_row) begin
          $error("draw_row: expected %0d, got %0d", want.draw_row, out_ch.draw_row);
          mismatch_count++;
        end
        if (out_ch.draw_code !== want.draw_code) begin
          $error("draw_code: expected %h, got %h", want.draw_code, out_ch.draw_code);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int                phase;
    int                start;
    logic [7:0]        cols_val;
    logic [7:0]        rows_val;
    logic [CODE_W-1:0] lead;
    logic [CODE_W-1:0] trail;
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    mismatch_count  = 0;
    items_sent      = 0;
    tx_mode         = 2;
    col_count_reg   = COLUMN_COUNT_RST;
    row_count_reg   = ROW_COUNT_RST;
    cur_col         = 0;
    cur_row         = 0;
    held_lead       = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].is_cfg) begin
        drain();
        write_reg(DIR_TAB[i].reg_idx, DIR_TAB[i].code[7:0]);
      end else begin
        send_char(DIR_TAB[i].code, DIR_TAB[i].known, DIR_TAB[i].want);
      end
    end

    for (phase = 0; phase < 9; phase++) begin
      cols_val = PHASE_COLS[phase];
      rows_val = PHASE_ROWS[phase];
      if (phase == 6) begin
        cols_val = 8'($urandom_range(0, 255));
        rows_val = 8'($urandom_range(0, 255));
      end else if (phase == 8) begin
        cols_val = 8'($urandom_range(2, 20));
        rows_val = 8'($urandom_range(2, 8));
      end
      drain();
      write_reg(CFG_COLUMN_COUNT, cols_val);
      write_reg(CFG_ROW_COUNT, rows_val);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 15) begin
          // well-formed double-byte pair, now and then with an odd trail
          lead = ($urandom_range(0, 1) != 0) ? CODE_W'($urandom_range(LEAD_A_LO, LEAD_A_HI))
                                             : CODE_W'($urandom_range(LEAD_B_LO, LEAD_B_HI));
          trail = ($urandom_range(0, 9) == 0) ? pick_code()
                                              : CODE_W'($urandom_range(16'h40, 16'hfc));
          send_char(lead, 1'b0, NO_DRAW);
          send_char(trail, 1'b0, NO_DRAW);
        end else begin
          send_char(pick_code(), 1'b0, NO_DRAW);
        end
        if ($urandom_range(0, 99) == 0) drain();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/tccp_pkg.sv
rtl/core/tccp_in_if.sv
rtl/core/tccp_out_if.sv
rtl/core/tccp_in_reg.sv
rtl/core/tccp_core.sv
rtl/core/text_console_cursor_placer.sv
rtl/core/tccp_checker.sv
test/text_console_cursor_placer_tb.sv
